// ===== rtl/core/argbcd_pkg.sv =====
`default_nettype none

package argbcd_pkg;

  // Line buffer depth: a line holds at most LINE_BUFFER_BYTES-1 stored bytes
  localparam int unsigned LINE_BUFFER_BYTES = 255;
  localparam int unsigned CNT_W             = $clog2(LINE_BUFFER_BYTES);
  localparam logic [CNT_W-1:0] CNT_LAST     = CNT_W'(LINE_BUFFER_BYTES - 1);

  // Field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned ACC_W   = 11;   // accum*10 + digit before saturation

  // Percent handling
  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;
  localparam logic [PCT_W-1:0] PCT_SAT = 7'd101;

  // Scaling: duty = (p*full + 50) / 100, divide done as (x*5243) >> 19,
  // exact for x below 25600
  localparam int unsigned PROD_W      = 15;
  localparam logic [PROD_W-1:0] ROUND = 15'd50;
  localparam int unsigned RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] RECIP = 13'd5243;
  localparam int unsigned RECIP_SHIFT = 19;
  localparam int unsigned QPROD_W     = PROD_W + RECIP_W;

  // Characters
  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
  localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

  // Register file
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic [LEVEL_W-1:0] FULL_SCALE_RST = 8'd255;

  typedef enum logic [1:0] {
    REG_RED   = 2'd0,
    REG_GREEN = 2'd1,
    REG_BLUE  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
  } full_scale_t;

  // Judged line, handed from the parser to the scaler
  typedef struct packed {
    logic             ok;
    logic [PCT_W-1:0] p_red;
    logic [PCT_W-1:0] p_green;
    logic [PCT_W-1:0] p_blue;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/argbcd_if.sv =====
`default_nettype none

interface argbcd_in_if;
  import argbcd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface argbcd_out_if;
  import argbcd_pkg::*;
  logic               valid;
  logic               ready;
  logic               line_ok;
  logic [LEVEL_W-1:0] red_duty;
  logic [LEVEL_W-1:0] green_duty;
  logic [LEVEL_W-1:0] blue_duty;

  modport source (output valid, output line_ok, output red_duty, output green_duty,
                  output blue_duty, input ready);
  modport sink   (input valid, input line_ok, input red_duty, input green_duty,
                  input blue_duty, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/argbcd_cfg.sv =====
`default_nettype none

module argbcd_cfg (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [argbcd_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [argbcd_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [argbcd_pkg::APB_DATA_W-1:0] prdata,
  output logic                                   pready,
  output argbcd_pkg::full_scale_t                full_scale_o
);
  import argbcd_pkg::*;

  full_scale_t fs_q, fs_d;
  reg_idx_e    idx;
  logic        wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[APB_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;

  // Register write decode
  always_comb begin
    fs_d = fs_q;
    if (wr_en) begin
      case (idx)
        REG_RED:   fs_d.red   = pwdata[LEVEL_W-1:0];
        REG_GREEN: fs_d.green = pwdata[LEVEL_W-1:0];
        REG_BLUE:  fs_d.blue  = pwdata[LEVEL_W-1:0];
        default:   fs_d = fs_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q <= '{red: FULL_SCALE_RST, green: FULL_SCALE_RST, blue: FULL_SCALE_RST};
    end else begin
      fs_q <= fs_d;
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      REG_RED:   prdata = APB_DATA_W'(fs_q.red);
      REG_GREEN: prdata = APB_DATA_W'(fs_q.green);
      REG_BLUE:  prdata = APB_DATA_W'(fs_q.blue);
      default:   prdata = '0;
    endcase
  end

  assign full_scale_o = fs_q;

endmodule

`default_nettype wire

// ===== rtl/core/argbcd_parse.sv =====
`default_nettype none

module argbcd_parse (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  argbcd_in_if.sink       in_i,
  input  wire logic       q_full_i,
  output logic            push_o,
  output argbcd_pkg::cmd_t cmd_o
);
  import argbcd_pkg::*;

  typedef enum logic [4:0] {
    PH_BEFORE = 5'b00001,
    PH_SIGN   = 5'b00010,
    PH_DIGITS = 5'b00100,
    PH_DONE   = 5'b01000,
    PH_FAIL   = 5'b10000
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [1:0]       field_q, field_d;
  logic [PCT_W-1:0] acc_q, acc_d;
  logic             minus_q, minus_d;
  logic             ended_q, ended_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [PCT_W-1:0] first_q, first_d;
  logic [PCT_W-1:0] second_q, second_d;

  logic              fire;
  logic [BYTE_W-1:0] c;
  logic              digit;
  logic              blank;
  logic [3:0]        dval;
  logic [ACC_W-1:0]  acc_next;
  logic [PCT_W-1:0]  cur_pct;

  assign in_i.ready = !q_full_i;
  assign fire       = in_i.valid && !q_full_i;
  assign c          = in_i.rx_byte;
  assign dval       = c[3:0];
  assign acc_next   = ACC_W'(acc_q) * ACC_W'(10) + ACC_W'(dval);

  always_comb begin
    digit = c inside {[CH_ZERO:CH_NINE]};
    blank = c inside {CH_SPACE, CH_TAB, CH_VT, CH_FF};
  end

  // Clamped percent of the number in progress
  always_comb begin
    if (minus_q) begin
      cur_pct = '0;
    end else if (acc_q > PCT_MAX) begin
      cur_pct = PCT_MAX;
    end else begin
      cur_pct = acc_q;
    end
  end

  // Per-byte parse
  always_comb begin
    phase_d  = phase_q;
    field_d  = field_q;
    acc_d    = acc_q;
    minus_d  = minus_q;
    ended_d  = ended_q;
    count_d  = count_q;
    first_d  = first_q;
    second_d = second_q;
    push_o   = 1'b0;
    cmd_o.ok      = (field_q == 2'd2) && (phase_q == PH_DONE || phase_q == PH_DIGITS);
    cmd_o.p_red   = first_q;
    cmd_o.p_green = second_q;
    cmd_o.p_blue  = cur_pct;

    if (fire && c != CH_CR) begin
      if (c == CH_LF || count_q >= CNT_LAST) begin
        // newline judges the line; an overlong line just restarts
        push_o  = (c == CH_LF);
        phase_d = PH_BEFORE;
        field_d = '0;
        acc_d   = '0;
        minus_d = 1'b0;
        ended_d = 1'b0;
        count_d = '0;
      end else begin
        count_d = count_q + CNT_W'(1);
        if (!ended_q) begin
          if (c == CH_NUL) begin
            ended_d = 1'b1;
          end else begin
            case (phase_q)
              PH_BEFORE: begin
                if (!blank) begin
                  acc_d   = '0;
                  minus_d = 1'b0;
                  if (c == CH_PLUS || c == CH_MINUS) begin
                    minus_d = (c == CH_MINUS);
                    phase_d = PH_SIGN;
                  end else if (digit) begin
                    acc_d   = PCT_W'(dval);
                    phase_d = PH_DIGITS;
                  end else begin
                    phase_d = PH_FAIL;
                  end
                end
              end
              PH_SIGN: begin
                if (digit) begin
                  acc_d   = PCT_W'(dval);
                  phase_d = PH_DIGITS;
                end else begin
                  phase_d = PH_FAIL;
                end
              end
              PH_DIGITS: begin
                if (digit) begin
                  acc_d = (acc_next > ACC_W'(PCT_MAX)) ? PCT_SAT : acc_next[PCT_W-1:0];
                end else if (field_q == 2'd2) begin
                  phase_d = PH_DONE;
                end else if (c == CH_COMMA) begin
                  if (field_q == 2'd0) begin
                    first_d = cur_pct;
                  end else begin
                    second_d = cur_pct;
                  end
                  field_d = field_q + 2'd1;
                  phase_d = PH_BEFORE;
                end else begin
                  phase_d = PH_FAIL;
                end
              end
              default: phase_d = phase_q;
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_BEFORE;
      field_q  <= '0;
      acc_q    <= '0;
      minus_q  <= 1'b0;
      ended_q  <= 1'b0;
      count_q  <= '0;
      first_q  <= '0;
      second_q <= '0;
    end else begin
      phase_q  <= phase_d;
      field_q  <= field_d;
      acc_q    <= acc_d;
      minus_q  <= minus_d;
      ended_q  <= ended_d;
      count_q  <= count_d;
      first_q  <= first_d;
      second_q <= second_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/argbcd_fifo.sv =====
`default_nettype none

module argbcd_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire argbcd_pkg::cmd_t  push_data_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   valid_o,
  output argbcd_pkg::cmd_t       pop_data_o
);
  import argbcd_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign full_o     = (count_q == 2'd2);
  assign valid_o    = (count_q != 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/argbcd_scale.sv =====
`default_nettype none

module argbcd_scale (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire argbcd_pkg::full_scale_t full_scale_i,
  input  wire logic                   cmd_valid_i,
  input  wire argbcd_pkg::cmd_t       cmd_i,
  output logic                        pop_o,
  argbcd_out_if.source                out_o
);
  import argbcd_pkg::*;

  logic               adv;

  // Stage A: p*full + 50
  logic               a_valid_q;
  logic               a_ok_q;
  logic [PROD_W-1:0]  a_red_q, a_green_q, a_blue_q;

  // Stage B: divide by 100, levels, result register
  logic [QPROD_W-1:0] q_red, q_green, q_blue;
  logic [LEVEL_W-1:0] red_d, green_d, blue_d;
  logic [LEVEL_W-1:0] red_q, green_q, blue_q;
  logic               out_valid_q;
  logic               out_ok_q;

  assign adv   = !out_valid_q || out_o.ready;
  assign pop_o = cmd_valid_i && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q <= cmd_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      a_ok_q    <= cmd_i.ok;
      a_red_q   <= PROD_W'(cmd_i.p_red) * PROD_W'(full_scale_i.red) + ROUND;
      a_green_q <= PROD_W'(cmd_i.p_green) * PROD_W'(full_scale_i.green) + ROUND;
      a_blue_q  <= PROD_W'(cmd_i.p_blue) * PROD_W'(full_scale_i.blue) + ROUND;
    end
  end

  // Reciprocal multiply for the divide by 100
  assign q_red   = QPROD_W'(a_red_q) * QPROD_W'(RECIP);
  assign q_green = QPROD_W'(a_green_q) * QPROD_W'(RECIP);
  assign q_blue  = QPROD_W'(a_blue_q) * QPROD_W'(RECIP);

  always_comb begin
    red_d   = red_q;
    green_d = green_q;
    blue_d  = blue_q;
    if (a_valid_q && a_ok_q) begin
      red_d   = q_red[RECIP_SHIFT +: LEVEL_W];
      green_d = q_green[RECIP_SHIFT +: LEVEL_W];
      blue_d  = q_blue[RECIP_SHIFT +: LEVEL_W];
    end
  end

  // Levels double as the result payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_ok_q    <= 1'b0;
      red_q       <= FULL_SCALE_RST;
      green_q     <= FULL_SCALE_RST;
      blue_q      <= FULL_SCALE_RST;
    end else if (adv) begin
      out_valid_q <= a_valid_q;
      if (a_valid_q) begin
        out_ok_q <= a_ok_q;
        red_q    <= red_d;
        green_q  <= green_d;
        blue_q   <= blue_d;
      end
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.line_ok    = out_ok_q;
  assign out_o.red_duty   = red_q;
  assign out_o.green_duty = green_q;
  assign out_o.blue_duty  = blue_q;

endmodule

`default_nettype wire

// ===== rtl/core/ascii_rgb_command_decoder.sv =====
// Parses received text lines "r,g,b" (percent values, sscanf "%d,%d,%d" rules) and
// turns each good line into three 8-bit duty levels, duty = (p*full_scale + 50)/100.
// One byte is taken every cycle; in_i.ready drops only while the two-entry command
// queue between the parser and the scaler is full, which happens only when results
// are not taken. Every newline yields one item on out_o, carried through the queue,
// the multiply stage and the divide-by-reciprocal stage into the result register;
// line_ok is 0 and the levels are kept for a bad line. Carriage returns are
// dropped, a NUL ends the parsed text, and a line of LINE_BUFFER_BYTES-1 stored bytes
// restarts the parser. Full-scale registers sit at byte offsets 0, 4 and 8.
`default_nettype none

module ascii_rgb_command_decoder (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  argbcd_in_if.sink                              in_i,
  argbcd_out_if.source                           out_o,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [argbcd_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [argbcd_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [argbcd_pkg::APB_DATA_W-1:0] prdata,
  output logic                                   pready
);
  import argbcd_pkg::*;

  full_scale_t full_scale;
  logic        push;
  cmd_t        push_cmd;
  logic        q_full;
  logic        pop;
  logic        q_valid;
  cmd_t        q_cmd;

  argbcd_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .full_scale_o (full_scale)
  );

  argbcd_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  argbcd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_cmd)
  );

  argbcd_scale u_scale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .full_scale_i (full_scale),
    .cmd_valid_i  (q_valid),
    .cmd_i        (q_cmd),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire
